// File: rtl/core/chbd_pkg.sv
// ----------------------------------------------------------------------------
// Cartridge header and boot-chip detect package
// Transfer types, header offsets, boot-chip kind codes and the small lookup
// functions shared by the detector.
// ----------------------------------------------------------------------------
package chbd_pkg;

   // Input transfer: one image byte, with a flag on the last byte.
   typedef struct packed {
      logic [7:0] rom_byte;
      logic       final_byte;
   } req_type;

   // Result transfer: one per image, sent after its last byte.
   typedef struct packed {
      logic        header_ok;
      logic [2:0]  cic_kind;
      logic [7:0]  boot_seed;
      logic [31:0] entry_address;
      logic [1:0]  tv_standard;
      logic [31:0] ipl3_crc;
      logic        ipl3_present;
      logic [31:0] boot_pc;
      logic [31:0] header_clock;
      logic [31:0] checksum_one;
      logic [31:0] checksum_two;
      logic [7:0]  region_code;
   } rsp_type;

   localparam int unsigned OFFSET_WIDTH = 13;

   // Offsets of the last byte of each captured header word, the region byte and the boot-code window bounds.
   localparam logic [OFFSET_WIDTH-1:0] OFS_CLOCK_END   = 13'h007;
   localparam logic [OFFSET_WIDTH-1:0] OFS_PC_END      = 13'h00B;
   localparam logic [OFFSET_WIDTH-1:0] OFS_CHECK1_END  = 13'h013;
   localparam logic [OFFSET_WIDTH-1:0] OFS_CHECK2_END  = 13'h017;
   localparam logic [OFFSET_WIDTH-1:0] OFS_COUNTRY     = 13'h03E;
   localparam logic [OFFSET_WIDTH-1:0] OFS_IPL_START   = 13'h040;
   localparam logic [OFFSET_WIDTH-1:0] OFS_IPL_END     = 13'h1000;

   localparam logic [31:0] CRC_POLY      = 32'hEDB8_8320;
   localparam logic [31:0] CRC_PRESET    = 32'hFFFF_FFFF;
   localparam logic [31:0] DEFAULT_ENTRY = 32'h8000_0400;

   // Known boot-code checksums.
   localparam logic [31:0] CRC_6101   = 32'h6170_A4A1;
   localparam logic [31:0] CRC_6102_A = 32'h90BB_6CB5;
   localparam logic [31:0] CRC_6102_B = 32'h0B05_0EE0;
   localparam logic [31:0] CRC_6103   = 32'h98BC_2C86;
   localparam logic [31:0] CRC_6105   = 32'hACC8_580A;
   localparam logic [31:0] CRC_6106_A = 32'h0E01_8FFF;
   localparam logic [31:0] CRC_6106_B = 32'hA536_C0F0;
   localparam logic [31:0] CRC_5101   = 32'hC2A1_67C6;
   localparam logic [31:0] CRC_X103   = 32'h009E_9EA3;

   // Boot-chip kind codes.
   localparam logic [2:0] KIND_NONE = 3'd0;
   localparam logic [2:0] KIND_6101 = 3'd1;
   localparam logic [2:0] KIND_6102 = 3'd2;
   localparam logic [2:0] KIND_6103 = 3'd3;
   localparam logic [2:0] KIND_6105 = 3'd4;
   localparam logic [2:0] KIND_6106 = 3'd5;
   localparam logic [2:0] KIND_5101 = 3'd6;
   localparam logic [2:0] KIND_X103 = 3'd7;

   // TV standard codes.
   localparam logic [1:0] TV_NTSC = 2'd0;
   localparam logic [1:0] TV_PAL  = 2'd1;
   localparam logic [1:0] TV_MPAL = 2'd2;

   localparam logic [7:0] SEED_6102 = 8'h3F;
   localparam logic [7:0] SEED_6103 = 8'h78;
   localparam logic [7:0] SEED_6105 = 8'h91;
   localparam logic [7:0] SEED_6106 = 8'h85;
   localparam logic [7:0] SEED_5101 = 8'hAC;

   localparam logic [31:0] PC_SHIFT_SMALL = 32'h0010_0000;
   localparam logic [31:0] PC_SHIFT_LARGE = 32'h0020_0000;

   // One byte of a reflected CRC-32, eight bit steps unrolled.
   function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] data);
      logic [31:0] c;
      c = crc ^ {24'd0, data};
      for (int i = 0; i < 8; i++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

   function automatic logic [2:0] kind_of_crc(input logic [31:0] crc);
      logic [2:0] k;
      case (crc)
         CRC_6101:               k = KIND_6101;
         CRC_6102_A, CRC_6102_B: k = KIND_6102;
         CRC_6103:               k = KIND_6103;
         CRC_6105:               k = KIND_6105;
         CRC_6106_A, CRC_6106_B: k = KIND_6106;
         CRC_5101:               k = KIND_5101;
         CRC_X103:               k = KIND_X103;
         default:                k = KIND_6102;
      endcase
      return k;
   endfunction

   function automatic logic [7:0] seed_of_kind(input logic [2:0] kind);
      logic [7:0] s;
      case (kind)
         KIND_6103, KIND_X103: s = SEED_6103;
         KIND_6105:            s = SEED_6105;
         KIND_6106:            s = SEED_6106;
         KIND_5101:            s = SEED_5101;
         default:              s = SEED_6102;
      endcase
      return s;
   endfunction

   function automatic logic [31:0] pc_shift_of_kind(input logic [2:0] kind);
      logic [31:0] p;
      case (kind)
         KIND_6103, KIND_5101, KIND_X103: p = PC_SHIFT_SMALL;
         KIND_6106:                       p = PC_SHIFT_LARGE;
         default:                         p = 32'd0;
      endcase
      return p;
   endfunction

   function automatic logic [1:0] tv_of_region(input logic [7:0] region);
      logic [1:0] t;
      case (region) inside
         "P", "D", "F", "I", "S", "H", "X", "Y", "W": t = TV_PAL;
         "B", "N":                                   t = TV_MPAL;
         default:                                    t = TV_NTSC;
      endcase
      return t;
   endfunction

endpackage

// File: rtl/core/cart_header_boot_detect.sv
// ----------------------------------------------------------------------------
// Cartridge header and boot-chip detector
// Streams an image byte by byte, captures header fields, checksums the boot
// code and reports the boot-chip kind once per image.
// ----------------------------------------------------------------------------
// The block takes one image byte per clock cycle with no gaps required on its
// side; the full byte-wide CRC-32 step is unrolled into the input-side state
// update, so a transfer can be accepted every cycle. The result for an image
// is captured in a snapshot register when its last byte is accepted; the
// checksum match and entry-address subtract then sit in front of the result
// register. Input is only held off when both the snapshot and result
// registers are full and the result is not taken.
// After the last byte the state returns to its reset values, so the next
// byte begins a new image at offset zero.
module cart_header_boot_detect (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  chbd_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output chbd_pkg::rsp_type rsp_data
);

   typedef struct packed {
      logic        header_ok;
      logic        full;
      logic [31:0] crc;
      logic [31:0] pc;
      logic [31:0] clock;
      logic [31:0] check_one;
      logic [31:0] check_two;
      logic [7:0]  country;
   } fin_type;

   logic [chbd_pkg::OFFSET_WIDTH-1:0] offset_ff, offset_in;
   logic [31:0] crc_ff, crc_in;
   logic [31:0] word_ff, word_in;
   logic [31:0] clock_ff, clock_in;
   logic [31:0] pc_ff, pc_in;
   logic [31:0] check_one_ff, check_one_in;
   logic [31:0] check_two_ff, check_two_in;
   logic [7:0]  country_ff, country_in;

   fin_type           fin_ff, fin_in;
   logic              fin_valid_ff, fin_valid_in;
   chbd_pkg::rsp_type rsp_ff, rsp_in;
   logic              rsp_valid_ff, rsp_valid_in;

   logic        req_fire;
   logic        rsp_free;
   logic        fin_move;
   logic [31:0] crc_final;
   logic [2:0]  kind;
   logic [31:0] entry_raw;

   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign fin_move  = fin_valid_ff && rsp_free;
   assign req_ready = !fin_valid_ff || rsp_free;
   assign req_fire  = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Input side: header capture and CRC, plus the end-of-image snapshot.
   always_comb begin
      offset_in    = offset_ff;
      crc_in       = crc_ff;
      word_in      = word_ff;
      clock_in     = clock_ff;
      pc_in        = pc_ff;
      check_one_in = check_one_ff;
      check_two_in = check_two_ff;
      country_in   = country_ff;
      fin_in       = fin_ff;

      if (req_fire) begin
         // Bytes past the boot-code window only move nothing; the offset saturates.
         if (offset_ff < chbd_pkg::OFS_IPL_END) begin
            word_in = {word_ff[23:0], req_data.rom_byte};
            if (offset_ff == chbd_pkg::OFS_CLOCK_END)  clock_in     = word_in;
            if (offset_ff == chbd_pkg::OFS_PC_END)     pc_in        = word_in;
            if (offset_ff == chbd_pkg::OFS_CHECK1_END) check_one_in = word_in;
            if (offset_ff == chbd_pkg::OFS_CHECK2_END) check_two_in = word_in;
            if (offset_ff == chbd_pkg::OFS_COUNTRY)    country_in   = req_data.rom_byte;
            if (offset_ff >= chbd_pkg::OFS_IPL_START) begin
               crc_in = chbd_pkg::crc_byte(crc_ff, req_data.rom_byte);
            end
            offset_in = offset_ff + 13'd1;
         end

         if (req_data.final_byte) begin
            fin_in.header_ok = (offset_in >= chbd_pkg::OFS_IPL_START);
            fin_in.full      = (offset_in >= chbd_pkg::OFS_IPL_END);
            fin_in.crc       = crc_in;
            fin_in.pc        = pc_in;
            fin_in.clock     = clock_in;
            fin_in.check_one = check_one_in;
            fin_in.check_two = check_two_in;
            fin_in.country   = country_in;

            offset_in    = '0;
            crc_in       = chbd_pkg::CRC_PRESET;
            word_in      = '0;
            clock_in     = '0;
            pc_in        = '0;
            check_one_in = '0;
            check_two_in = '0;
            country_in   = '0;
         end
      end

      if (req_fire && req_data.final_byte) begin
         fin_valid_in = 1'b1;
      end else if (fin_move) begin
         fin_valid_in = 1'b0;
      end else begin
         fin_valid_in = fin_valid_ff;
      end
   end

   // Result side: kind match, seed and entry address from the snapshot.
   always_comb begin
      crc_final = ~fin_ff.crc;
      kind      = fin_ff.full ? chbd_pkg::kind_of_crc(crc_final) : chbd_pkg::KIND_6102;
      entry_raw = fin_ff.pc - chbd_pkg::pc_shift_of_kind(kind);

      rsp_in = '0;
      if (fin_ff.header_ok) begin
         rsp_in.header_ok     = 1'b1;
         rsp_in.cic_kind      = kind;
         rsp_in.boot_seed     = chbd_pkg::seed_of_kind(kind);
         rsp_in.entry_address = (entry_raw == 32'd0) ? chbd_pkg::DEFAULT_ENTRY : entry_raw;
         rsp_in.tv_standard   = chbd_pkg::tv_of_region(fin_ff.country);
         rsp_in.ipl3_crc      = fin_ff.full ? crc_final : 32'd0;
         rsp_in.ipl3_present  = fin_ff.full;
         rsp_in.boot_pc       = fin_ff.pc;
         rsp_in.header_clock  = fin_ff.clock;
         rsp_in.checksum_one  = fin_ff.check_one;
         rsp_in.checksum_two  = fin_ff.check_two;
         rsp_in.region_code   = fin_ff.country;
      end

      if (fin_move) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff    <= '0;
         crc_ff       <= chbd_pkg::CRC_PRESET;
         word_ff      <= '0;
         clock_ff     <= '0;
         pc_ff        <= '0;
         check_one_ff <= '0;
         check_two_ff <= '0;
         country_ff   <= '0;
         fin_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         offset_ff    <= offset_in;
         crc_ff       <= crc_in;
         word_ff      <= word_in;
         clock_ff     <= clock_in;
         pc_ff        <= pc_in;
         check_one_ff <= check_one_in;
         check_two_ff <= check_two_in;
         country_ff   <= country_in;
         fin_valid_ff <= fin_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      fin_ff <= fin_in;
      if (fin_move) begin
         rsp_ff <= rsp_in;
      end
   end

   // The byte counter never runs past the end of the boot-code window.
   assert property (@(posedge clock) disable iff (reset)
      offset_ff <= chbd_pkg::OFS_IPL_END)
      else $error("byte offset ran past its saturation point");

   // The last byte of an image restarts the capture state.
   assert property (@(posedge clock) disable iff (reset)
      req_fire && req_data.final_byte |=>
         offset_ff == '0 && crc_ff == chbd_pkg::CRC_PRESET && pc_ff == '0)
      else $error("state not restarted after the last byte");

   // A short header gives an all-zero result.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ff.header_ok |->
         rsp_ff.cic_kind == chbd_pkg::KIND_NONE && rsp_ff.entry_address == 32'd0 &&
         rsp_ff.ipl3_present == 1'b0)
      else $error("short header result carries nonzero fields");

   // Without boot code the kind defaults and the checksum is zero.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.header_ok && !rsp_ff.ipl3_present |->
         rsp_ff.cic_kind == chbd_pkg::KIND_6102 && rsp_ff.ipl3_crc == 32'd0)
      else $error("short image result has wrong kind or checksum");

   // A result is only loaded from a pending snapshot.
   assert property (@(posedge clock) disable iff (reset)
      !fin_valid_ff && !rsp_valid_ff |=> !rsp_valid_ff)
      else $error("result appeared without a snapshot");

endmodule

// File: bench/tb_top.sv
// ----------------------------------------------------------------------------
// Testbench for the cartridge header and boot-chip detector
// Streams whole images through the byte channel and predicts one header
// result per image. Runs of tiny images, images just short of and exactly at
// the header size, and random images are mixed. Both channels idle and stall
// at random.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int unsigned IDLE_LIMIT    = 3000;
   localparam int unsigned LONG_HOLD     = 300;
   localparam int unsigned RANDOM_BYTES  = 1200;
   localparam int unsigned RANDOM_IMAGES = 15;

   typedef struct packed {
      logic              wait_drain;
      chbd_pkg::req_type beat;
   } queued_byte_t;

   logic              clock     = 1'b0;
   logic              reset     = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   chbd_pkg::req_type req_data  = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   chbd_pkg::rsp_type rsp_data;

   queued_byte_t      pending_bytes[$];
   chbd_pkg::rsp_type header_expectations[$];
   int unsigned       mismatch_count = 0;

   // Image state as seen by the predictor.
   logic [chbd_pkg::OFFSET_WIDTH-1:0] img_pos    = '0;
   logic [31:0]                       run_crc    = chbd_pkg::CRC_PRESET;
   logic [31:0]                       shift_acc  = '0;
   logic [31:0]                       cap_clock  = '0;
   logic [31:0]                       cap_pc     = '0;
   logic [31:0]                       cap_check1 = '0;
   logic [31:0]                       cap_check2 = '0;
   logic [7:0]                        cap_region = '0;

   // Sender and receiver pacing.
   int unsigned burst_left = 0;
   int unsigned gap_left   = 0;
   int unsigned hold_left  = 0;
   bit          long_hold_done = 1'b0;
   int unsigned mode_left  = 0;
   int unsigned ready_mode = 0;
   int unsigned idle_cycles = 0;

   string       region_chars = "EJU7PDFISHXYWBNQ";
   logic [31:0] known_crcs [9] = '{chbd_pkg::CRC_6101, chbd_pkg::CRC_6102_A,
      chbd_pkg::CRC_6102_B, chbd_pkg::CRC_6103, chbd_pkg::CRC_6105, chbd_pkg::CRC_6106_A,
      chbd_pkg::CRC_6106_B, chbd_pkg::CRC_5101, chbd_pkg::CRC_X103};

   cart_header_boot_detect uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // Bit-serial form of the reflected CRC-32 over one byte.
   function automatic logic [31:0] crc_fold_byte(logic [31:0] c, logic [7:0] d);
      logic fb;
      for (int i = 0; i < 8; i++) begin
         fb = c[0] ^ d[i];
         c  = c >> 1;
         if (fb) c = c ^ chbd_pkg::CRC_POLY;
      end
      return c;
   endfunction

   // Runs 32 bit steps of the CRC backwards. Four appended bytes act like one
   // word XORed into the register, so this gives the word that steers the
   // register onto a chosen value.
   function automatic logic [31:0] crc_unwind(logic [31:0] f);
      for (int i = 0; i < 32; i++) begin
         if (f[31]) f = ((f ^ chbd_pkg::CRC_POLY) << 1) | 32'd1;
         else f = f << 1;
      end
      return f;
   endfunction

   function automatic logic [2:0] chip_kind(logic [31:0] crc);
      case (crc)
         chbd_pkg::CRC_6101:                         return chbd_pkg::KIND_6101;
         chbd_pkg::CRC_6103:                         return chbd_pkg::KIND_6103;
         chbd_pkg::CRC_6105:                         return chbd_pkg::KIND_6105;
         chbd_pkg::CRC_6106_A, chbd_pkg::CRC_6106_B: return chbd_pkg::KIND_6106;
         chbd_pkg::CRC_5101:                         return chbd_pkg::KIND_5101;
         chbd_pkg::CRC_X103:                         return chbd_pkg::KIND_X103;
         default:                                    return chbd_pkg::KIND_6102;
      endcase
   endfunction

   function automatic logic [7:0] chip_seed(logic [2:0] kind);
      case (kind)
         chbd_pkg::KIND_6103, chbd_pkg::KIND_X103: return chbd_pkg::SEED_6103;
         chbd_pkg::KIND_6105:                      return chbd_pkg::SEED_6105;
         chbd_pkg::KIND_6106:                      return chbd_pkg::SEED_6106;
         chbd_pkg::KIND_5101:                      return chbd_pkg::SEED_5101;
         default:                                  return chbd_pkg::SEED_6102;
      endcase
   endfunction

   function automatic logic [31:0] entry_shift(logic [2:0] kind);
      case (kind)
         chbd_pkg::KIND_6103, chbd_pkg::KIND_5101, chbd_pkg::KIND_X103:
            return chbd_pkg::PC_SHIFT_SMALL;
         chbd_pkg::KIND_6106:
            return chbd_pkg::PC_SHIFT_LARGE;
         default:
            return 32'd0;
      endcase
   endfunction

   function automatic logic [1:0] tv_for_region(logic [7:0] r);
      case (r) inside
         "P", "D", "F", "I", "S", "H", "X", "Y", "W": return chbd_pkg::TV_PAL;
         "B", "N":                                   return chbd_pkg::TV_MPAL;
         default:                                    return chbd_pkg::TV_NTSC;
      endcase
   endfunction

   // Folds one accepted byte into the image state and, on the last byte,
   // queues the header result that the block must return.
   task automatic absorb_byte(chbd_pkg::req_type t);
      chbd_pkg::rsp_type r;
      logic [31:0]       crc;
      logic [31:0]       entry;
      logic [2:0]        kind;
      logic              full;
      if (img_pos < chbd_pkg::OFS_IPL_END) begin
         shift_acc = {shift_acc[23:0], t.rom_byte};
         case (img_pos)
            chbd_pkg::OFS_CLOCK_END:  cap_clock  = shift_acc;
            chbd_pkg::OFS_PC_END:     cap_pc     = shift_acc;
            chbd_pkg::OFS_CHECK1_END: cap_check1 = shift_acc;
            chbd_pkg::OFS_CHECK2_END: cap_check2 = shift_acc;
            chbd_pkg::OFS_COUNTRY:    cap_region = t.rom_byte;
            default: ;
         endcase
         if (img_pos >= chbd_pkg::OFS_IPL_START) run_crc = crc_fold_byte(run_crc, t.rom_byte);
         img_pos = img_pos + 13'd1;
      end
      if (t.final_byte) begin
         r = '0;
         if (img_pos >= chbd_pkg::OFS_IPL_START) begin
            full  = img_pos >= chbd_pkg::OFS_IPL_END;
            crc   = full ? ~run_crc : 32'd0;
            kind  = full ? chip_kind(crc) : chbd_pkg::KIND_6102;
            entry = cap_pc - entry_shift(kind);
            if (entry == 32'd0) entry = chbd_pkg::DEFAULT_ENTRY;
            r.header_ok     = 1'b1;
            r.cic_kind      = kind;
            r.boot_seed     = chip_seed(kind);
            r.entry_address = entry;
            r.tv_standard   = tv_for_region(cap_region);
            r.ipl3_crc      = crc;
            r.ipl3_present  = full;
            r.boot_pc       = cap_pc;
            r.header_clock  = cap_clock;
            r.checksum_one  = cap_check1;
            r.checksum_two  = cap_check2;
            r.region_code   = cap_region;
         end
         header_expectations.push_back(r);
         img_pos    = '0;
         run_crc    = chbd_pkg::CRC_PRESET;
         shift_acc  = '0;
         cap_clock  = '0;
         cap_pc     = '0;
         cap_check1 = '0;
         cap_check2 = '0;
         cap_region = '0;
      end
   endtask

   // Builds one image of random bytes with a chosen boot address and region
   // byte. With pin_crc set on an image of at least 4 KiB, the last four
   // boot-code bytes are chosen so that the checksum equals crc_target.
   task automatic queue_image(int unsigned len, logic [31:0] pc, logic [7:0] region,
                              bit pin_crc, logic [31:0] crc_target, bit wait_drain);
      logic [7:0]   img [];
      logic [31:0]  c;
      logic [31:0]  tail;
      queued_byte_t q;
      img = new[len];
      foreach (img[i]) img[i] = 8'($urandom);
      for (int i = 0; i < 4; i++) begin
         if (8 + i < len) img[8 + i] = pc[31 - 8 * i -: 8];
      end
      if (len > chbd_pkg::OFS_COUNTRY) img[chbd_pkg::OFS_COUNTRY] = region;
      if (pin_crc && len >= chbd_pkg::OFS_IPL_END) begin
         c = chbd_pkg::CRC_PRESET;
         for (int i = chbd_pkg::OFS_IPL_START; i < chbd_pkg::OFS_IPL_END - 4; i++) begin
            c = crc_fold_byte(c, img[i]);
         end
         tail = crc_unwind(~crc_target) ^ c;
         for (int i = 0; i < 4; i++) img[chbd_pkg::OFS_IPL_END - 4 + i] = tail[8 * i +: 8];
      end
      foreach (img[i]) begin
         q.wait_drain      = wait_drain && (i == 0);
         q.beat.rom_byte   = img[i];
         q.beat.final_byte = (i == len - 1);
         pending_bytes.push_back(q);
      end
   endtask

   function automatic logic [31:0] pick_pc();
      case ($urandom_range(0, 5))
         0:       return 32'd0;
         1:       return chbd_pkg::PC_SHIFT_SMALL;
         2:       return chbd_pkg::PC_SHIFT_LARGE;
         3:       return chbd_pkg::DEFAULT_ENTRY;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [7:0] pick_region();
      if ($urandom_range(0, 3) == 0) return 8'($urandom);
      return region_chars[$urandom_range(0, 15)];
   endfunction

   task automatic flag_mismatch(string msg);
      mismatch_count++;
      $display("[%0t] mismatch: %s", $realtime, msg);
   endtask

   task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want) flag_mismatch($sformatf("%s got %h want %h", name, got, want));
   endtask

   // Byte sender: holds each byte until the transfer, then offers the next
   // one unless it is in a gap or waiting for all results to drain.
   always @(posedge clock) begin : byte_sender
      logic take;
      logic next_valid;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         take = req_valid && req_ready;
         if (take) begin
            absorb_byte(pending_bytes[0].beat);
            void'(pending_bytes.pop_front());
            if (burst_left > 0) burst_left--;
            if (burst_left == 0) begin
               burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(200, 600)
                                                        : $urandom_range(1, 30);
               gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            end
         end
         if (!req_valid || take) begin
            if (gap_left > 0) begin
               gap_left--;
               next_valid = 1'b0;
            end else if (pending_bytes.size() == 0) begin
               next_valid = 1'b0;
            end else if (pending_bytes[0].wait_drain && header_expectations.size() != 0) begin
               next_valid = 1'b0;
            end else begin
               next_valid = 1'b1;
            end
            req_valid <= next_valid;
            if (next_valid) req_data <= pending_bytes[0].beat;
         end
      end
   end

   // Result receiver: one long hold-off at the first result, then a stall
   // pattern that switches among always ready, half and quarter rate.
   always @(posedge clock) begin : result_receiver
      chbd_pkg::rsp_type want;
      logic              next_ready;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (header_expectations.size() == 0) begin
               flag_mismatch("result transfer with no image outstanding");
            end else begin
               want = header_expectations.pop_front();
               check_field("header_ok", 32'(rsp_data.header_ok), 32'(want.header_ok));
               check_field("cic_kind", 32'(rsp_data.cic_kind), 32'(want.cic_kind));
               check_field("boot_seed", 32'(rsp_data.boot_seed), 32'(want.boot_seed));
               check_field("entry_address", rsp_data.entry_address, want.entry_address);
               check_field("tv_standard", 32'(rsp_data.tv_standard), 32'(want.tv_standard));
               check_field("ipl3_crc", rsp_data.ipl3_crc, want.ipl3_crc);
               check_field("ipl3_present", 32'(rsp_data.ipl3_present),
                           32'(want.ipl3_present));
               check_field("boot_pc", rsp_data.boot_pc, want.boot_pc);
               check_field("header_clock", rsp_data.header_clock, want.header_clock);
               check_field("checksum_one", rsp_data.checksum_one, want.checksum_one);
               check_field("checksum_two", rsp_data.checksum_two, want.checksum_two);
               check_field("region_code", 32'(rsp_data.region_code), 32'(want.region_code));
            end
         end
         if (hold_left > 0) begin
            hold_left--;
            next_ready = 1'b0;
         end else if (!long_hold_done && rsp_valid) begin
            long_hold_done = 1'b1;
            hold_left      = LONG_HOLD - 1;
            next_ready     = 1'b0;
         end else begin
            if (mode_left == 0) begin
               ready_mode = $urandom_range(0, 2);
               mode_left  = $urandom_range(10, 80);
            end else begin
               mode_left--;
            end
            case (ready_mode)
               0:       next_ready = 1'b1;
               1:       next_ready = 1'($urandom_range(0, 1));
               default: next_ready = ($urandom_range(0, 3) == 0);
            endcase
         end
         rsp_ready <= next_ready;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      int unsigned rand_bytes;
      int unsigned rand_images;
      int unsigned len;
      int unsigned sel;

      // A run of tiny images first, so the results pile up behind the long
      // receiver hold-off and the block has to stall its input.
      for (int i = 0; i < 10; i++) queue_image(1 + i % 3, 32'd0, 8'd0, 1'b0, 32'd0, 1'b0);
      queue_image(63, $urandom, "E", 1'b0, 32'd0, 1'b0);
      queue_image(64, 32'd0, "P", 1'b0, 32'd0, 1'b1);

      rand_bytes  = 0;
      rand_images = 0;
      while (rand_bytes < RANDOM_BYTES || rand_images < RANDOM_IMAGES) begin
         sel = $urandom_range(0, 99);
         if (sel < 30) begin
            len = $urandom_range(1, 63);
         end else begin
            len = $urandom_range(64, 90);
         end
         queue_image(len, pick_pc(), pick_region(), 1'($urandom_range(0, 1)),
                     known_crcs[$urandom_range(0, 8)], $urandom_range(0, 19) == 0);
         rand_bytes += len;
         rand_images++;
      end

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      do @(posedge clock);
      while (pending_bytes.size() != 0 || req_valid || header_expectations.size() != 0);
      repeat (8) @(posedge clock);
      if (header_expectations.size() != 0) flag_mismatch("results still outstanding at end");
      if (mismatch_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

// File: filelist.f
rtl/core/chbd_pkg.sv
rtl/core/cart_header_boot_detect.sv
bench/tb_top.sv
